FILE: hw/rtl/fmpf_pkg.sv
package fmpf_pkg;

   // Table depth and the widths that follow from it.
   localparam int RULE_DEPTH = 256;
   localparam int IDX_W      = $clog2(RULE_DEPTH);
   localparam int CNT_W      = IDX_W + 1;

   // Request kinds.
   localparam logic [1:0] KIND_CHECK  = 2'd0;
   localparam logic [1:0] KIND_ADD    = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

   // Wildcard and default codes of the rule class.
   localparam logic [1:0] PROTO_WILD = 2'd0;
   localparam logic [1:0] BOOT_PROTO = 2'd1;
   localparam logic [1:0] DIR_IN     = 2'd0;
   localparam logic [1:0] DIR_WILD   = 2'd2;

   localparam logic [15:0] BOOT_PORTS [4] = '{16'd22, 16'd80, 16'd443, 16'd8080};

   // One table entry. For a latched request the ident field carries the target id.
   typedef struct packed {
      logic [31:0] ident;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] sport;
      logic [15:0] dport;
      logic        action;
      logic [1:0]  proto;
      logic [1:0]  dir;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

   // Outcome of comparing one stored rule with the latched request.
   typedef struct packed {
      logic hit;
      logic deny;
      logic id_hit;
   } match_type;

   // Contents of the four rules that reset loads.
   function automatic rule_type default_rule(input logic [1:0] idx);
      rule_type r;
      r       = '0;
      r.ident = 32'(idx) + 32'd1;
      r.proto = BOOT_PROTO;
      r.dir   = DIR_IN;
      r.dport = BOOT_PORTS[idx];
      return r;
   endfunction

endpackage

FILE: hw/rtl/fmpf_ram.sv
module fmpf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fmpf_match.sv
module fmpf_match (
   input  fmpf_pkg::rule_type  rule,
   input  fmpf_pkg::rule_type  pkt,
   output fmpf_pkg::match_type result
);
   import fmpf_pkg::*;

   logic proto_ok;
   logic dir_ok;
   logic addr_ok;
   logic port_ok;

   // Zero fields in a rule are wildcards; direction uses its own wildcard code.
   always_comb begin
      proto_ok = (rule.proto == PROTO_WILD) || (rule.proto == pkt.proto);
      dir_ok   = (rule.dir == DIR_WILD) || (rule.dir == pkt.dir);
      addr_ok  = ((rule.src == '0) || (rule.src == pkt.src)) &&
                 ((rule.dst == '0) || (rule.dst == pkt.dst));
      port_ok  = ((rule.sport == '0) || (rule.sport == pkt.sport)) &&
                 ((rule.dport == '0) || (rule.dport == pkt.dport));
      result.hit    = proto_ok && dir_ok && addr_ok && port_ok;
      result.deny   = rule.action;
      result.id_hit = (rule.ident == pkt.ident);
   end

endmodule

FILE: hw/rtl/first_match_packet_filter_table.sv
// Channel   Direction  Handshake                 Contents
// req_      in         req_valid / req_ready     kind, rule or packet fields, target id
// rsp_      out        rsp_valid / rsp_ready     verdict, status, new id, tallies
// csr_      in         csr_write_enable          filter_on bit, no wait, no read-back
//
// One request is handled at a time. A check or remove reads the rule memory one
// entry per cycle through its single read port, walking the used entries in order;
// a remove then moves each later entry down one place at one entry per cycle.
// An add, a check with the filter off and an unused kind go through OP and RESP.
// After reset the block writes the four default rules in INIT before it
// takes a request. A waiting response holds only the next request's final step.
module first_match_packet_filter_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic        req_action,
   input  logic [1:0]  req_protocol,
   input  logic [1:0]  req_direction,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_dest_address,
   input  logic [15:0] req_source_port,
   input  logic [15:0] req_dest_port,
   input  logic [31:0] req_target_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_verdict,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_new_id,
   output logic [31:0] rsp_allowed_count,
   output logic [31:0] rsp_blocked_count,
   output logic [31:0] rsp_total_count,
   output logic [31:0] rsp_last_denied_source,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import fmpf_pkg::*;

   // Controller states. INIT loads the default rules, OP handles the requests that
   // need no table walk, SCAN walks the table, SHIFT closes the gap after a remove
   // and RESP waits for the response register to be free.
   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_OP    = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_SHIFT = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  init_ff, init_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic        q_valid_ff, q_valid_in;
   logic [IDX_W-1:0] q_idx_ff, q_idx_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] allowed_ff, allowed_in;
   logic [31:0] blocked_ff, blocked_in;
   logic [31:0] checked_ff, checked_in;
   logic [31:0] last_denied_ff, last_denied_in;
   logic        filter_on_ff, filter_on_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // Latched request and pending result (payload, no reset).
   logic [1:0]  kind_ff, kind_in;
   rule_type    req_rule_ff, req_rule_in;
   logic        res_verdict_ff, res_verdict_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic [31:0] res_nid_ff, res_nid_in;

   // Response register.
   logic        out_verdict_ff, out_verdict_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic [31:0] out_nid_ff, out_nid_in;
   logic [31:0] out_allowed_ff, out_allowed_in;
   logic [31:0] out_blocked_ff, out_blocked_in;
   logic [31:0] out_checked_ff, out_checked_in;
   logic [31:0] out_denied_ff, out_denied_in;

   // Rule memory port.
   logic             ram_we;
   logic [IDX_W-1:0] ram_wa;
   rule_type         ram_wd;
   logic [IDX_W-1:0] ram_ra;
   logic [RULE_W-1:0] ram_rd;
   rule_type         rd_rule;
   match_type        match;
   logic             issue;

   assign rd_rule = rule_type'(ram_rd);

   fmpf_ram #(
      .WIDTH (RULE_W),
      .DEPTH (RULE_DEPTH)
   ) u_rules (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   fmpf_match u_match (
      .rule   (rd_rule),
      .pkt    (req_rule_ff),
      .result (match)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      init_in        = init_ff;
      used_in        = used_ff;
      rd_ptr_in      = rd_ptr_ff;
      q_valid_in     = 1'b0;
      q_idx_in       = q_idx_ff;
      id_in          = id_ff;
      allowed_in     = allowed_ff;
      blocked_in     = blocked_ff;
      checked_in     = checked_ff;
      last_denied_in = last_denied_ff;
      filter_on_in   = csr_write_enable ? csr_write_data : filter_on_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      kind_in        = kind_ff;
      req_rule_in    = req_rule_ff;
      res_verdict_in = res_verdict_ff;
      res_status_in  = res_status_ff;
      res_nid_in     = res_nid_ff;
      out_verdict_in = out_verdict_ff;
      out_status_in  = out_status_ff;
      out_nid_in     = out_nid_ff;
      out_allowed_in = out_allowed_ff;
      out_blocked_in = out_blocked_ff;
      out_checked_in = out_checked_ff;
      out_denied_in  = out_denied_ff;
      ram_we         = 1'b0;
      ram_wa         = '0;
      ram_wd         = req_rule_ff;
      ram_ra         = rd_ptr_ff[IDX_W-1:0];
      issue          = 1'b0;

      case (state_ff)
         ST_INIT: begin
            ram_we  = 1'b1;
            ram_wa  = IDX_W'(init_ff);
            ram_wd  = default_rule(init_ff);
            init_in = init_ff + 2'd1;
            if (init_ff == 2'd3) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in           = req_kind;
               req_rule_in.ident = req_target_id;
               req_rule_in.src   = req_source_address;
               req_rule_in.dst   = req_dest_address;
               req_rule_in.sport = req_source_port;
               req_rule_in.dport = req_dest_port;
               req_rule_in.action = req_action;
               req_rule_in.proto = req_protocol;
               req_rule_in.dir   = req_direction;
               rd_ptr_in         = '0;
               res_verdict_in    = 1'b0;
               res_status_in     = STATUS_OK;
               res_nid_in        = '0;
               if ((req_kind == KIND_CHECK) && filter_on_ff) begin
                  checked_in = checked_ff + 32'd1;
                  state_in   = ST_SCAN;
               end else if (req_kind == KIND_REMOVE) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_OP;
               end
            end
         end
         ST_OP: begin
            // A check here has the filter off; kind 3 changes nothing.
            if (kind_ff == KIND_CHECK) begin
               res_verdict_in = 1'b1;
            end else if (kind_ff == KIND_ADD) begin
               if (used_ff >= CNT_W'(RULE_DEPTH)) begin
                  res_status_in = STATUS_FULL;
               end else begin
                  ram_we       = 1'b1;
                  ram_wa       = used_ff[IDX_W-1:0];
                  ram_wd.ident = id_ff;
                  res_nid_in   = id_ff;
                  id_in        = id_ff + 32'd1;
                  used_in      = used_ff + CNT_W'(1);
               end
            end
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            issue = (rd_ptr_ff < used_ff);
            if (issue) begin
               rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
               q_idx_in   = rd_ptr_ff[IDX_W-1:0];
               q_valid_in = 1'b1;
            end
            if (q_valid_ff && (kind_ff == KIND_CHECK) && match.hit) begin
               if (!match.deny) begin
                  allowed_in     = allowed_ff + 32'd1;
                  res_verdict_in = 1'b1;
               end else begin
                  blocked_in     = blocked_ff + 32'd1;
                  last_denied_in = req_rule_ff.src;
               end
               q_valid_in = 1'b0;
               state_in   = ST_RESP;
            end else if (q_valid_ff && (kind_ff == KIND_REMOVE) && match.id_hit) begin
               // The read of the next entry is already in flight: keep streaming.
               state_in = ST_SHIFT;
            end else if (!q_valid_ff && !issue) begin
               if (kind_ff == KIND_CHECK) begin
                  blocked_in = blocked_ff + 32'd1;
               end else begin
                  res_status_in = STATUS_NOTFOUND;
               end
               state_in = ST_RESP;
            end
         end
         ST_SHIFT: begin
            issue = (rd_ptr_ff < used_ff);
            if (issue) begin
               rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
               q_idx_in   = rd_ptr_ff[IDX_W-1:0];
               q_valid_in = 1'b1;
            end
            if (q_valid_ff) begin
               ram_we = 1'b1;
               ram_wa = q_idx_ff - IDX_W'(1);
               ram_wd = rd_rule;
            end else begin
               used_in  = used_ff - CNT_W'(1);
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               out_verdict_in = res_verdict_ff;
               out_status_in  = res_status_ff;
               out_nid_in     = res_nid_ff;
               out_allowed_in = allowed_ff;
               out_blocked_in = blocked_ff;
               out_checked_in = checked_ff;
               out_denied_in  = last_denied_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         init_ff        <= '0;
         used_ff        <= CNT_W'(4);
         rd_ptr_ff      <= '0;
         q_valid_ff     <= 1'b0;
         id_ff          <= 32'd5;
         allowed_ff     <= '0;
         blocked_ff     <= '0;
         checked_ff     <= '0;
         last_denied_ff <= '0;
         filter_on_ff   <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         init_ff        <= init_in;
         used_ff        <= used_in;
         rd_ptr_ff      <= rd_ptr_in;
         q_valid_ff     <= q_valid_in;
         id_ff          <= id_in;
         allowed_ff     <= allowed_in;
         blocked_ff     <= blocked_in;
         checked_ff     <= checked_in;
         last_denied_ff <= last_denied_in;
         filter_on_ff   <= filter_on_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_idx_ff       <= q_idx_in;
      kind_ff        <= kind_in;
      req_rule_ff    <= req_rule_in;
      res_verdict_ff <= res_verdict_in;
      res_status_ff  <= res_status_in;
      res_nid_ff     <= res_nid_in;
      out_verdict_ff <= out_verdict_in;
      out_status_ff  <= out_status_in;
      out_nid_ff     <= out_nid_in;
      out_allowed_ff <= out_allowed_in;
      out_blocked_ff <= out_blocked_in;
      out_checked_ff <= out_checked_in;
      out_denied_ff  <= out_denied_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_verdict            = out_verdict_ff;
   assign rsp_status             = out_status_ff;
   assign rsp_new_id             = out_nid_ff;
   assign rsp_allowed_count      = out_allowed_ff;
   assign rsp_blocked_count      = out_blocked_ff;
   assign rsp_total_count        = out_checked_ff;
   assign rsp_last_denied_source = out_denied_ff;

   // The fill count never exceeds the table depth.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(RULE_DEPTH))
      else $error("rule count above table depth");

   // A full-table response never carries an id.
   a_full_no_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_FULL)) |-> (rsp_new_id == '0))
      else $error("full status with nonzero id");

   // Finishing a shift removes exactly one rule.
   a_shift_drops_one: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHIFT) && !q_valid_ff) |=> (used_ff == $past(used_ff) - CNT_W'(1)))
      else $error("remove did not shrink the table by one");

   // The table walk of a check or a search never writes the memory.
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_we)
      else $error("memory written during scan");

endmodule
